// ----- rtl/button_debounce_click_classifier_assert.svh -----
// assertion macros shared by the click classifier rtl
`ifndef BUTTON_DEBOUNCE_CLICK_CLASSIFIER_ASSERT_SVH
`define BUTTON_DEBOUNCE_CLICK_CLASSIFIER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define BDCC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bdcc check failed");

// next-cycle implication, sampled on clk, off during reset
`define BDCC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bdcc check failed");

`endif

// ----- rtl/bdcc_pkg.sv -----
// shared types and constants of the button debounce click classifier
package bdcc_pkg;

	localparam int NumButtons = 4;
	localparam int BtnW       = 2;
	localparam int HoldW      = 16;
	localparam int DebW       = 4;
	localparam int MaskW      = 4;
	localparam int KindW      = 3;
	localparam int CfgIdxW    = 3;
	localparam int CfgDataW   = 16;
	localparam int BitCntW    = 4;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_ENABLE   = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_POLARITY = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_EVALUATE = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_LONG     = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_PERIOD   = 3'd5;
	localparam logic [CfgIdxW-1:0] CFG_ABORT    = 3'd6;

	typedef enum logic [KindW-1:0] {
		EV_STABLE        = 3'd0,
		EV_PRESSED       = 3'd1,
		EV_RELEASED_HOLD = 3'd2,
		EV_LONG_CLICK    = 3'd3,
		EV_SHORT_CLICK   = 3'd4,
		EV_STILL_PRESSED = 3'd5,
		EV_ABORT         = 3'd6
	} event_kind_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_BOUNCE,
		CMD_ACCEPT,
		CMD_CLICK,
		CMD_ABORT,
		CMD_INC,
		CMD_MOD_START,
		CMD_MOD_STEP,
		CMD_STILL,
		CMD_FLUSH
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t           op;
		logic [BtnW-1:0]   btn;
	} cmd_t;

	typedef struct packed {
		logic tick_acc;
		logic enabled;
		logic differ;
		logic bounce_done;
		logic eval_on;
		logic click_act;
		logic hold_zero;
		logic is_abort;
		logic period_zero;
		logic rem_zero;
		logic mod_last;
		logic emit_ok;
		logic flush_ok;
		logic pend_v;
	} status_t;

endpackage

// ----- rtl/bdcc_if.sv -----
// tick and event channel interfaces
interface bdcc_tick_if;
	logic                        valid;
	logic                        ready;
	logic [bdcc_pkg::MaskW-1:0]  raw_levels;

	modport source (output valid, output raw_levels, input ready);
	modport sink   (input valid, input raw_levels, output ready);
endinterface

interface bdcc_event_if;
	logic                        valid;
	logic                        ready;
	logic [bdcc_pkg::BtnW-1:0]   button_index;
	logic [bdcc_pkg::KindW-1:0]  event_kind;
	logic                        level;
	logic [bdcc_pkg::HoldW-1:0]  hold_count;
	logic                        last_of_tick;

	modport source (output valid, output button_index, output event_kind, output level,
		output hold_count, output last_of_tick, input ready);
	modport sink   (input valid, input button_index, input event_kind, input level,
		input hold_count, input last_of_tick, output ready);
endinterface

// ----- rtl/bdcc_datapath.sv -----
// datapath: config registers, per-button state, serial remainder, event buffers
module bdcc_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bdcc_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [bdcc_pkg::CfgDataW-1:0]  cfg_data,
	bdcc_tick_if.sink                      ticks,
	bdcc_event_if.source                   events,
	input  bdcc_pkg::cmd_t                 cmd,
	output bdcc_pkg::status_t              sts
);

	logic [bdcc_pkg::MaskW-1:0]  enable_q, polarity_q, evaluate_q, raw_q;
	logic [bdcc_pkg::DebW-1:0]   debounce_q;
	logic [bdcc_pkg::HoldW-1:0]  long_q, period_q, abort_q;

	logic                        stable_q [bdcc_pkg::NumButtons];
	logic [bdcc_pkg::DebW-1:0]   bounce_q [bdcc_pkg::NumButtons];
	logic [bdcc_pkg::HoldW-1:0]  hold_q   [bdcc_pkg::NumButtons];

	logic [bdcc_pkg::HoldW-1:0]    rem_q;
	logic [bdcc_pkg::BitCntW-1:0]  bit_q;

	logic                        pend_v_q;
	logic [bdcc_pkg::BtnW-1:0]   pend_btn_q;
	logic [bdcc_pkg::KindW-1:0]  pend_kind_q;
	logic                        pend_lvl_q;
	logic [bdcc_pkg::HoldW-1:0]  pend_hold_q;

	logic                        out_v_q;
	logic [bdcc_pkg::BtnW-1:0]   out_btn_q;
	logic [bdcc_pkg::KindW-1:0]  out_kind_q;
	logic                        out_lvl_q;
	logic [bdcc_pkg::HoldW-1:0]  out_hold_q;
	logic                        out_last_q;

	logic [bdcc_pkg::BtnW-1:0]   b;
	logic                        lvl;
	logic [bdcc_pkg::HoldW-1:0]  hold;
	logic                        hold_zero;
	logic                        emit;
	bdcc_pkg::event_kind_t       new_kind;
	bdcc_pkg::event_kind_t       rel_kind;
	logic                        new_lvl;
	logic [bdcc_pkg::HoldW-1:0]  new_hold;
	logic [bdcc_pkg::HoldW:0]    rem_shift;
	logic [bdcc_pkg::HoldW-1:0]  rem_next;

	// selected button view
	assign b         = cmd.btn;
	assign lvl       = raw_q[b] ^ polarity_q[b];
	assign hold      = hold_q[b];
	assign hold_zero = (hold == '0);

	// release classification
	always_comb begin
		if (hold > period_q) begin
			rel_kind = bdcc_pkg::EV_RELEASED_HOLD;
		end else if (hold > long_q) begin
			rel_kind = bdcc_pkg::EV_LONG_CLICK;
		end else begin
			rel_kind = bdcc_pkg::EV_SHORT_CLICK;
		end
	end

	// one remainder bit step
	always_comb begin
		rem_shift = {rem_q, hold[bit_q]};
		if (rem_shift >= {1'b0, period_q}) begin
			rem_next = bdcc_pkg::HoldW'(rem_shift - {1'b0, period_q});
		end else begin
			rem_next = rem_shift[bdcc_pkg::HoldW-1:0];
		end
	end

	// event built by the current command
	always_comb begin
		emit     = 1'b0;
		new_kind = bdcc_pkg::EV_STABLE;
		new_lvl  = 1'b0;
		new_hold = '0;
		case (cmd.op)
			bdcc_pkg::CMD_ACCEPT: begin
				emit    = 1'b1;
				new_lvl = lvl;
			end
			bdcc_pkg::CMD_CLICK: begin
				emit = 1'b1;
				if (hold_zero) begin
					new_kind = bdcc_pkg::EV_PRESSED;
				end else begin
					new_kind = rel_kind;
					new_hold = hold;
				end
			end
			bdcc_pkg::CMD_ABORT: begin
				emit     = 1'b1;
				new_kind = bdcc_pkg::EV_ABORT;
				new_hold = abort_q;
			end
			bdcc_pkg::CMD_STILL: begin
				emit     = 1'b1;
				new_kind = bdcc_pkg::EV_STILL_PRESSED;
				new_hold = hold;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// status to the controller; in idle the tick input is always ready
	always_comb begin
		sts.tick_acc    = ticks.valid;
		sts.enabled     = enable_q[b];
		sts.differ      = (lvl != stable_q[b]);
		sts.bounce_done = (bounce_q[b] >= debounce_q);
		sts.eval_on     = evaluate_q[b];
		sts.click_act   = (hold_zero && lvl) || (!hold_zero && !lvl);
		sts.hold_zero   = hold_zero;
		sts.is_abort    = (hold == abort_q);
		sts.period_zero = (period_q == '0);
		sts.rem_zero    = (rem_q == '0);
		sts.mod_last    = (bit_q == '0);
		sts.emit_ok     = !pend_v_q || !out_v_q || events.ready;
		sts.flush_ok    = !out_v_q || events.ready;
		sts.pend_v      = pend_v_q;
	end

	assign ticks.ready = (cmd.op == bdcc_pkg::CMD_LOAD);

	assign events.valid        = out_v_q;
	assign events.button_index = out_btn_q;
	assign events.event_kind   = out_kind_q;
	assign events.level        = out_lvl_q;
	assign events.hold_count   = out_hold_q;
	assign events.last_of_tick = out_last_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= '0;
			polarity_q <= '0;
			evaluate_q <= '0;
			debounce_q <= bdcc_pkg::DebW'(4);
			long_q     <= '0;
			period_q   <= '0;
			abort_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bdcc_pkg::CFG_ENABLE:   enable_q   <= cfg_data[bdcc_pkg::MaskW-1:0];
				bdcc_pkg::CFG_POLARITY: polarity_q <= cfg_data[bdcc_pkg::MaskW-1:0];
				bdcc_pkg::CFG_EVALUATE: evaluate_q <= cfg_data[bdcc_pkg::MaskW-1:0];
				bdcc_pkg::CFG_DEBOUNCE: debounce_q <= cfg_data[bdcc_pkg::DebW-1:0];
				bdcc_pkg::CFG_LONG:     long_q     <= cfg_data;
				bdcc_pkg::CFG_PERIOD:   period_q   <= cfg_data;
				bdcc_pkg::CFG_ABORT:    abort_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// tick sample and remainder unit
	always_ff @(posedge clk) begin
		if (ticks.valid && ticks.ready) begin
			raw_q <= ticks.raw_levels;
		end
		if (cmd.op == bdcc_pkg::CMD_MOD_START) begin
			rem_q <= '0;
			bit_q <= '1;
		end else if (cmd.op == bdcc_pkg::CMD_MOD_STEP) begin
			rem_q <= rem_next;
			bit_q <= bit_q - 1'b1;
		end
	end

	// per-button debounce and hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < bdcc_pkg::NumButtons; k++) begin
				stable_q[k] <= 1'b0;
				bounce_q[k] <= '0;
				hold_q[k]   <= '0;
			end
		end else begin
			case (cmd.op)
				bdcc_pkg::CMD_BOUNCE: bounce_q[b] <= bounce_q[b] + 1'b1;
				bdcc_pkg::CMD_ACCEPT: begin
					stable_q[b] <= lvl;
					bounce_q[b] <= '0;
				end
				bdcc_pkg::CMD_CLICK:  hold_q[b] <= hold_zero ? bdcc_pkg::HoldW'(1) : '0;
				bdcc_pkg::CMD_ABORT:  hold_q[b] <= '0;
				bdcc_pkg::CMD_INC,
				bdcc_pkg::CMD_STILL:  hold_q[b] <= hold + 1'b1;
				default: begin
				end
			endcase
		end
	end

	// pending event and output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (events.ready) begin
				out_v_q <= 1'b0;
			end
			if (emit) begin
				pend_v_q <= 1'b1;
				if (pend_v_q) begin
					out_v_q <= 1'b1;
				end
			end else if (cmd.op == bdcc_pkg::CMD_FLUSH) begin
				pend_v_q <= 1'b0;
				out_v_q  <= 1'b1;
			end
		end
	end

	// pending event and output payload
	always_ff @(posedge clk) begin
		if (emit) begin
			pend_btn_q  <= b;
			pend_kind_q <= new_kind;
			pend_lvl_q  <= new_lvl;
			pend_hold_q <= new_hold;
		end
		if ((emit && pend_v_q) || cmd.op == bdcc_pkg::CMD_FLUSH) begin
			out_btn_q  <= pend_btn_q;
			out_kind_q <= pend_kind_q;
			out_lvl_q  <= pend_lvl_q;
			out_hold_q <= pend_hold_q;
			out_last_q <= (cmd.op == bdcc_pkg::CMD_FLUSH);
		end
	end

endmodule

// ----- rtl/bdcc_controller.sv -----
// controller: walks the buttons through debounce, then hold evaluation
module bdcc_controller (
	input  logic               clk,
	input  logic               arst_n,
	input  bdcc_pkg::status_t  sts,
	output bdcc_pkg::cmd_t     cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEB,
		S_CLK,
		S_EVL,
		S_MOD,
		S_MCHK,
		S_END
	} state_t;

	state_t                    state_q;
	logic [bdcc_pkg::BtnW-1:0] btn_q;
	bdcc_pkg::cmd_op_t         op;
	logic                      stall;
	logic                      last_btn;

	assign last_btn = (btn_q == bdcc_pkg::BtnW'(bdcc_pkg::NumButtons - 1));
	assign cmd.op   = op;
	assign cmd.btn  = btn_q;

	// command selection
	always_comb begin
		op    = bdcc_pkg::CMD_NONE;
		stall = 1'b0;
		unique case (state_q)
			S_IDLE: op = bdcc_pkg::CMD_LOAD;
			S_DEB: begin
				if (sts.enabled && sts.differ) begin
					if (!sts.bounce_done) begin
						op = bdcc_pkg::CMD_BOUNCE;
					end else if (sts.emit_ok) begin
						op = bdcc_pkg::CMD_ACCEPT;
					end else begin
						stall = 1'b1;
					end
				end
			end
			S_CLK: begin
				if (sts.emit_ok) op = bdcc_pkg::CMD_CLICK;
				else stall = 1'b1;
			end
			S_EVL: begin
				if (sts.eval_on && !sts.hold_zero) begin
					if (sts.is_abort) begin
						if (sts.emit_ok) op = bdcc_pkg::CMD_ABORT;
						else stall = 1'b1;
					end else if (sts.period_zero) begin
						op = bdcc_pkg::CMD_INC;
					end else begin
						op = bdcc_pkg::CMD_MOD_START;
					end
				end
			end
			S_MOD: op = bdcc_pkg::CMD_MOD_STEP;
			S_MCHK: begin
				if (!sts.rem_zero) op = bdcc_pkg::CMD_INC;
				else if (sts.emit_ok) op = bdcc_pkg::CMD_STILL;
				else stall = 1'b1;
			end
			S_END: begin
				if (sts.pend_v) begin
					if (sts.flush_ok) op = bdcc_pkg::CMD_FLUSH;
					else stall = 1'b1;
				end
			end
			default: op = bdcc_pkg::CMD_NONE;
		endcase
	end

	// state and button index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			btn_q   <= '0;
		end else if (!stall) begin
			unique case (state_q)
				S_IDLE: begin
					if (sts.tick_acc) begin
						state_q <= S_DEB;
						btn_q   <= '0;
					end
				end
				S_DEB, S_CLK: begin
					if (state_q == S_DEB && op == bdcc_pkg::CMD_ACCEPT
						&& sts.eval_on && sts.click_act) begin
						state_q <= S_CLK;
					end else if (last_btn) begin
						state_q <= S_EVL;
						btn_q   <= '0;
					end else begin
						state_q <= S_DEB;
						btn_q   <= btn_q + 1'b1;
					end
				end
				S_EVL, S_MCHK: begin
					if (state_q == S_EVL && op == bdcc_pkg::CMD_MOD_START) begin
						state_q <= S_MOD;
					end else if (last_btn) begin
						state_q <= S_END;
					end else begin
						state_q <= S_EVL;
						btn_q   <= btn_q + 1'b1;
					end
				end
				S_MOD: begin
					if (sts.mod_last) state_q <= S_MCHK;
				end
				S_END: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/button_debounce_click_classifier.sv -----
// Four-button debouncer and click classifier. One tick transaction is taken
// in the idle cycle, then a controller visits each button once for debounce
// (plus a click step when a press or release event follows) and once for hold
// evaluation (with a bit-serial remainder of the hold counter by the period,
// one bit a cycle, when a still-pressed period is set and the button is held).
// The walk stalls while the event buffers are full and the event sink is not
// ready. Events leave through an output register behind a one-deep pending
// slot, which lets the last event of a tick be flagged.
module button_debounce_click_classifier (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bdcc_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [bdcc_pkg::CfgDataW-1:0]  cfg_data,
	bdcc_tick_if.sink                      ticks,
	bdcc_event_if.source                   events
);

`include "button_debounce_click_classifier_assert.svh"

	bdcc_pkg::cmd_t    cmd;
	bdcc_pkg::status_t sts;
	logic              emit_cmd;

	// sequencing
	bdcc_controller u_ctl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// state, arithmetic and event buffering
	bdcc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ticks     (ticks),
		.events    (events),
		.cmd       (cmd),
		.sts       (sts)
	);

	// commands that produce an event
	assign emit_cmd = cmd.op == bdcc_pkg::CMD_ACCEPT || cmd.op == bdcc_pkg::CMD_CLICK
		|| cmd.op == bdcc_pkg::CMD_ABORT || cmd.op == bdcc_pkg::CMD_STILL;

	// a tick transaction leaves the block busy
	`BDCC_ASSERT_NEXT(a_busy_after_tick, ticks.valid && ticks.ready, !ticks.ready)
	// every event of a tick is flushed before the next tick is taken
	`BDCC_ASSERT_IMPL(a_idle_no_pending, ticks.ready, !sts.pend_v)
	// events are only issued when the buffers have room
	`BDCC_ASSERT_IMPL(a_emit_room, emit_cmd, sts.emit_ok)

endmodule
